// ===== rtl/triangle_face_normal_core_assert.svh =====
// Assertion macros for the triangle face normal core.
// Used by the top level; expects a clk and rst in scope.
`ifndef TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TFN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfn check failed");

// Next-cycle implication, checked outside reset.
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfn check failed");

`endif

// ===== rtl/tfn_pkg.sv =====
// Shared types, constants and helper functions for the triangle face normal core.
// No dependencies.
package tfn_pkg;

  localparam int SLOT_W  = 10;
  localparam int FIELD_W = 16;
  localparam int NORM_W  = 16;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CROSS_W = 35;
  localparam int MAG_W   = 34;
  localparam int A_W     = 24;
  localparam int SUM_W   = 50;
  localparam int ROOT_W  = 25;
  localparam int Q_W     = 15;
  localparam int NUM_W   = 40;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0] READ_LAST   = 5'd2;
  localparam logic [CNT_W-1:0] CROSS_LAST  = 5'd6;
  localparam logic [CNT_W-1:0] SQUARE_LAST = 5'd3;
  localparam logic [CNT_W-1:0] SQRT_LAST   = 5'd24;
  localparam logic [CNT_W-1:0] DIV_LAST    = 5'd14;
  localparam logic [1:0]       AXIS_LAST   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EDGE, S_CROSS, S_ABS, S_NORM,
    S_SQUARE, S_SQRT, S_DIV_INIT, S_DIV_STEP, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_READ, OP_EDGE, OP_CROSS, OP_ABS, OP_NORM,
    OP_SQUARE, OP_SQRT, OP_DIV_INIT, OP_DIV_STEP
  } dp_op_t;

  typedef struct packed {
    logic             wr;
    logic             take;
    dp_op_t           op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       k;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic big;
    logic small_mag;
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] vertex_slot;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;
    logic [SLOT_W-1:0] first_corner;
    logic [SLOT_W-1:0] second_corner;
    logic [SLOT_W-1:0] third_corner;
    logic              last_triangle;
  } req_t;

  // Operand axes of the six cross-product terms, in issue order.
  function automatic logic [1:0] cross_sel_a(input logic [2:0] s);
    case (s)
      3'd0:    cross_sel_a = 2'd1;
      3'd1:    cross_sel_a = 2'd2;
      3'd2:    cross_sel_a = 2'd2;
      3'd3:    cross_sel_a = 2'd0;
      3'd4:    cross_sel_a = 2'd0;
      default: cross_sel_a = 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] cross_sel_b(input logic [2:0] s);
    case (s)
      3'd0:    cross_sel_b = 2'd2;
      3'd1:    cross_sel_b = 2'd1;
      3'd2:    cross_sel_b = 2'd0;
      3'd3:    cross_sel_b = 2'd2;
      3'd4:    cross_sel_b = 2'd1;
      default: cross_sel_b = 2'd0;
    endcase
  endfunction

endpackage

// ===== rtl/tfn_req_if.sv =====
// Input channel: valid/ready handshake with vertex or triangle payload.
// Depends on tfn_pkg.
interface tfn_req_if import tfn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SLOT_W-1:0]  vertex_slot;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [FIELD_W-1:0] pos_z;
  logic [SLOT_W-1:0]  first_corner;
  logic [SLOT_W-1:0]  second_corner;
  logic [SLOT_W-1:0]  third_corner;
  logic               last_triangle;

  modport source (output valid, mode, vertex_slot, pos_x, pos_y, pos_z,
                  first_corner, second_corner, third_corner, last_triangle,
                  input ready);
  modport sink (input valid, mode, vertex_slot, pos_x, pos_y, pos_z,
                first_corner, second_corner, third_corner, last_triangle,
                output ready);
endinterface

// ===== rtl/tfn_rsp_if.sv =====
// Output channel: valid/ready handshake carrying one unit normal word.
// Depends on tfn_pkg.
interface tfn_rsp_if import tfn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;
  logic                     degenerate;
  logic                     end_of_mesh;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, end_of_mesh,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, end_of_mesh,
                output ready);
endinterface

// ===== rtl/triangle_face_normal_core.sv =====
// A vertex write is taken while idle; a triangle runs from accept through the squares,
// the square root, three divides and the normalize shifts to its result register (a degenerate
// one skips the squares, root and divides), and the core is idle again before the next word.
// The result sits in an output register, so a new word is taken while it waits.
// Reset (rst, synchronous, active high) clears the controller and output valid;
// the vertex store holds no reset value and must be written before it is read.
module triangle_face_normal_core import tfn_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic     clk,
  input  logic     rst,
  tfn_req_if.sink  req,
  tfn_rsp_if.source rsp
);

  `include "triangle_face_normal_core_assert.svh"

  cmd_t    cmd;
  status_t status;
  req_t    req_word;
  logic    norm_zero;
  logic    norm_in_range;

  assign req_word = '{
    mode:          req.mode,
    vertex_slot:   req.vertex_slot,
    pos_x:         req.pos_x,
    pos_y:         req.pos_y,
    pos_z:         req.pos_z,
    first_corner:  req.first_corner,
    second_corner: req.second_corner,
    third_corner:  req.third_corner,
    last_triangle: req.last_triangle
  };

  tfn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_mode   (req.mode),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tfn_datapath #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .req         (req_word),
    .cmd         (cmd),
    .status      (status),
    .normal_x    (rsp.normal_x),
    .normal_y    (rsp.normal_y),
    .normal_z    (rsp.normal_z),
    .degenerate  (rsp.degenerate),
    .end_of_mesh (rsp.end_of_mesh)
  );

  assign norm_zero = (rsp.normal_x == '0) && (rsp.normal_y == '0) && (rsp.normal_z == '0);
  assign norm_in_range = (rsp.normal_x <= 16384) && (rsp.normal_x >= -16384) &&
                         (rsp.normal_y <= 16384) && (rsp.normal_y >= -16384) &&
                         (rsp.normal_z <= 16384) && (rsp.normal_z >= -16384);

  `TFN_ASSERT_NOW(a_degen_zero, rsp.valid && rsp.degenerate, norm_zero)
  `TFN_ASSERT_NOW(a_unit_range, rsp.valid, norm_in_range)
  `TFN_ASSERT_NEXT(a_busy_after_tri, req.valid && req.ready && req.mode, !req.ready)

endmodule

// ===== rtl/tfn_datapath.sv =====
// Datapath: vertex store, shared multiplier, bit-serial square root and divider.
// Driven by tfn_ctrl through cmd_t; depends on tfn_pkg.
module tfn_datapath import tfn_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                     clk,
  input  req_t                     req,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic signed [NORM_W-1:0] normal_x,
  output logic signed [NORM_W-1:0] normal_y,
  output logic signed [NORM_W-1:0] normal_z,
  output logic                     degenerate,
  output logic                     end_of_mesh
);

  localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int EW = CW + 1;
  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int MW = 3 * CW;

  logic [MW-1:0] mem [VERTEX_DEPTH];
  logic [MW-1:0] rdata;
  logic          rd_ok;

  logic [SLOT_W-1:0] corner [3];
  logic              last;

  logic signed [CW-1:0] v0 [3];
  logic signed [CW-1:0] v1 [3];
  logic signed [CW-1:0] vr [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [CROSS_W-1:0] cr [3];
  logic [MAG_W-1:0]          a [3];
  logic                      neg [3];

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sx, sr, sbit;
  logic [SUM_W:0]   trial;

  logic [NUM_W-1:0] num, dsh;
  logic [Q_W-1:0]   q, q_next;
  logic             fits;
  logic signed [NORM_W-1:0] n [3];

  logic [SLOT_W-1:0] rslot;
  logic [AW+SLOT_W-1:0] waddr_ext, raddr_ext;
  logic              w_in_range, r_in_range;
  logic [2:0]        cidx;
  logic [2:0]        jidx;
  logic [ROOT_W-1:0] root;

  // Store port: write on a vertex word, read one corner a cycle.
  assign waddr_ext  = {{AW{1'b0}}, req.vertex_slot};
  assign w_in_range = ({22'b0, req.vertex_slot} < VERTEX_DEPTH);

  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    rslot = corner[0];
      2'd1:    rslot = corner[1];
      default: rslot = corner[2];
    endcase
  end
  assign raddr_ext  = {{AW{1'b0}}, rslot};
  assign r_in_range = ({22'b0, rslot} < VERTEX_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.wr && w_in_range) begin
      mem[waddr_ext[AW-1:0]] <= {req.pos_z[CW-1:0], req.pos_y[CW-1:0], req.pos_x[CW-1:0]};
    end
    rdata <= mem[raddr_ext[AW-1:0]];
    rd_ok <= r_in_range;
  end

  // Out-of-range slots read as zero.
  always_comb begin
    vr[0] = rd_ok ? signed'(rdata[CW-1:0])      : '0;
    vr[1] = rd_ok ? signed'(rdata[2*CW-1:CW])   : '0;
    vr[2] = rd_ok ? signed'(rdata[3*CW-1:2*CW]) : '0;
  end

  // Shared multiplier operands.
  assign cidx = cmd.cnt[2:0];
  assign jidx = cidx - 3'd1;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == OP_CROSS) begin
      mul_a = MUL_W'(e1[cross_sel_a(cidx)]);
      mul_b = MUL_W'(e2[cross_sel_b(cidx)]);
    end else if (cmd.op == OP_SQUARE) begin
      mul_a = signed'({1'b0, a[cidx[1:0] == 2'd3 ? 2'd0 : cidx[1:0]][A_W-1:0]});
      mul_b = mul_a;
    end
  end

  assign status.zero      = (a[0] == '0) && (a[1] == '0) && (a[2] == '0);
  assign status.big       = |{a[0][MAG_W-1:A_W], a[1][MAG_W-1:A_W], a[2][MAG_W-1:A_W]};
  assign status.small_mag = !status.big && !(a[0][A_W-1] | a[1][A_W-1] | a[2][A_W-1])
                            && !status.zero;

  assign trial = {1'b0, sr} + {1'b0, sbit};
  assign root  = sr[ROOT_W-1:0];
  assign fits  = (num >= dsh);
  assign q_next = {q[Q_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      corner[0] <= req.first_corner;
      corner[1] <= req.second_corner;
      corner[2] <= req.third_corner;
      last      <= req.last_triangle;
    end
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_READ: begin
        if (cmd.cnt[1:0] == 2'd1) v0 <= vr;
        if (cmd.cnt[1:0] == 2'd2) v1 <= vr;
      end
      OP_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= EW'(v1[i]) - EW'(v0[i]);
          e2[i] <= EW'(vr[i]) - EW'(v0[i]);
        end
      end
      OP_CROSS: begin
        // Pair terms: even one loads, odd one subtracts.
        if (cidx != 3'd0) begin
          if (!jidx[0]) cr[jidx[2:1]] <= prod[CROSS_W-1:0];
          else          cr[jidx[2:1]] <= cr[jidx[2:1]] - prod[CROSS_W-1:0];
        end
      end
      OP_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= cr[i][CROSS_W-1];
          a[i]   <= cr[i][CROSS_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (status.big)            a[i] <= a[i] >> 1;
          else if (status.small_mag) a[i] <= a[i] << 1;
        end
      end
      OP_SQUARE: begin
        if (cidx == 3'd1) begin
          sum <= prod[SUM_W-1:0];
        end else if (cidx != 3'd0) begin
          sum <= sum + prod[SUM_W-1:0];
        end
        if (cidx == SQUARE_LAST[2:0]) begin
          sx   <= sum + prod[SUM_W-1:0];
          sr   <= '0;
          sbit <= SUM_W'(1) << (2 * (ROOT_W - 1));
        end
      end
      OP_SQRT: begin
        if ({1'b0, sx} >= trial) begin
          sx <= sx - trial[SUM_W-1:0];
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_DIV_INIT: begin
        num <= NUM_W'({a[cmd.k == 2'd3 ? 2'd0 : cmd.k][A_W-1:0], 15'b0}) + NUM_W'(root);
        dsh <= NUM_W'({root, 1'b0}) << (Q_W - 1);
        q   <= '0;
      end
      OP_DIV_STEP: begin
        if (fits) num <= num - dsh;
        dsh <= dsh >> 1;
        q   <= q_next;
        if (cmd.cnt == DIV_LAST) begin
          n[cmd.k == 2'd3 ? 2'd0 : cmd.k] <= neg[cmd.k == 2'd3 ? 2'd0 : cmd.k]
                                             ? -signed'(NORM_W'(q_next))
                                             : signed'(NORM_W'(q_next));
        end
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      normal_x    <= status.zero ? '0 : n[0];
      normal_y    <= status.zero ? '0 : n[1];
      normal_z    <= status.zero ? '0 : n[2];
      degenerate  <= status.zero;
      end_of_mesh <= last;
    end
  end

endmodule

// ===== rtl/tfn_ctrl.sv =====
// Controller: sequences store reads, cross product, normalize, root and divides.
// Drives tfn_datapath through cmd_t; depends on tfn_pkg.
module tfn_ctrl import tfn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_mode,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      if (cmd.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    k_next       = k;
    in_ready     = 1'b0;
    cmd.wr       = 1'b0;
    cmd.take     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.cnt      = cnt;
    cmd.k        = k;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.take   = 1'b1;
            cnt_next   = '0;
            state_next = S_READ;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.op = OP_READ;
        if (cnt == READ_LAST) begin
          cnt_next   = '0;
          state_next = S_EDGE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EDGE: begin
        cmd.op     = OP_EDGE;
        cnt_next   = '0;
        state_next = S_CROSS;
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (cnt == CROSS_LAST) begin
          cnt_next   = '0;
          state_next = S_ABS;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ABS: begin
        cmd.op     = OP_ABS;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (status.zero) begin
          state_next = S_DONE;
        end else if (!status.big && !status.small_mag) begin
          cnt_next   = '0;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.op = OP_SQUARE;
        if (cnt == SQUARE_LAST) begin
          cnt_next   = '0;
          state_next = S_SQRT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt == SQRT_LAST) begin
          k_next     = '0;
          state_next = S_DIV_INIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == DIV_LAST) begin
          if (k == AXIS_LAST) begin
            state_next = S_DONE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_DIV_INIT;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== bench/triangle_face_normal_core_tb.sv =====
// Self-checking bench for triangle_face_normal_core: vertex writes and unit face normals.
// Depends on tfn_pkg and the tfn_req_if / tfn_rsp_if channel interfaces from the RTL.
module triangle_face_normal_core_tb;
  import tfn_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RAND_ITEMS  = 830;

  typedef struct {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     deg;
    logic                     eom;
  } normal_t;

  typedef struct {
    req_t    word;
    bit      typed;
    normal_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfn_req_if req ();
  tfn_rsp_if rsp ();

  triangle_face_normal_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int          pos_model [DEPTH][3];
  bit          slot_written [DEPTH];
  logic [9:0]  written_slots [$];
  stim_row_t   stim_q [$];
  stim_row_t   sent_q [$];
  normal_t     normal_q [$];
  int          mismatches = 0;
  int          cyc = 0;
  bit          sender_done = 1'b0;

  function automatic void add_row(input stim_row_t r);
    stim_q.insert(stim_q.size(), r);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t face_normal(input logic [9:0] s0, s1, s2, input logic last);
    longint          e1 [3];
    longint          e2 [3];
    longint          c [3];
    longint unsigned a [3];
    longint unsigned mx, sum, len, q;
    int              k, sh;
    normal_t         n;
    for (k = 0; k < 3; k++) begin
      e1[k] = longint'(pos_model[s1][k]) - longint'(pos_model[s0][k]);
      e2[k] = longint'(pos_model[s2][k]) - longint'(pos_model[s0][k]);
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    n.eom = last;
    n.deg = 1'b0;
    mx = 0;
    for (k = 0; k < 3; k++) begin
      a[k] = (c[k] < 0) ? longint'(-c[k]) : longint'(c[k]);
      if (a[k] > mx) mx = a[k];
    end
    if (mx == 0) begin
      n.nx = '0; n.ny = '0; n.nz = '0; n.deg = 1'b1;
      return n;
    end
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 24)) sh++;
    if (sh > 0) begin
      for (k = 0; k < 3; k++) a[k] >>= sh;
    end else begin
      while (mx < (64'd1 << 23)) begin
        mx <<= 1;
        sh++;
      end
      for (k = 0; k < 3; k++) a[k] <<= sh;
    end
    sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    len = int_sqrt(sum);
    for (k = 0; k < 3; k++) begin
      q = (a[k] * 32768 + len) / (2 * len);
      if (c[k] < 0) q = -q;
      case (k)
        0: n.nx = q[15:0];
        1: n.ny = q[15:0];
        default: n.nz = q[15:0];
      endcase
    end
    return n;
  endfunction

  function automatic stim_row_t vertex_row(input logic [9:0] s, input logic [15:0] x, y, z);
    stim_row_t r;
    r.word = '0;
    r.word.mode = 1'b0;
    r.word.vertex_slot = s;
    r.word.pos_x = x;
    r.word.pos_y = y;
    r.word.pos_z = z;
    r.word.first_corner = 10'($urandom);
    r.word.second_corner = 10'($urandom);
    r.word.third_corner = 10'($urandom);
    r.word.last_triangle = 1'($urandom);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t tri_row(input logic [9:0] s0, s1, s2, input logic last);
    stim_row_t r;
    r.word = '0;
    r.word.mode = 1'b1;
    r.word.vertex_slot = 10'($urandom);
    r.word.pos_x = 16'($urandom);
    r.word.pos_y = 16'($urandom);
    r.word.pos_z = 16'($urandom);
    r.word.first_corner = s0;
    r.word.second_corner = s1;
    r.word.third_corner = s2;
    r.word.last_triangle = last;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input stim_row_t r, input logic signed [15:0] x, y, z,
                                          input logic d);
    r.typed = 1'b1;
    r.want.nx = x;
    r.want.ny = y;
    r.want.nz = z;
    r.want.deg = d;
    r.want.eom = r.word.last_triangle;
    return r;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  // Directed table, then random traffic biased toward triangles over written slots.
  initial begin
    logic [9:0] s, c0, c1, c2;
    add_row(vertex_row(10'd0, 16'h0000, 16'h0000, 16'h0000));
    add_row(vertex_row(10'd1, 16'h0100, 16'h0000, 16'h0000));
    add_row(vertex_row(10'd2, 16'h0000, 16'h0100, 16'h0000));
    add_row(vertex_row(10'd3, 16'h0000, 16'h0000, 16'h0100));
    add_row(vertex_row(10'd1023, 16'h7fff, 16'h7fff, 16'h7fff));
    add_row(vertex_row(10'd512, 16'h8000, 16'h8000, 16'h8000));
    add_row(vertex_row(10'd4, 16'h7fff, 16'h8000, 16'h0001));
    add_row(vertex_row(10'd5, 16'h8000, 16'h7fff, 16'hffff));
    add_row(vertex_row(10'd6, 16'h0001, 16'h0001, 16'h0000));
    // all corners equal: zero normal, degenerate
    add_row(typed_row(tri_row(10'd0, 10'd0, 10'd0, 1'b0), 16'sd0, 16'sd0, 16'sd0, 1'b1));
    add_row(typed_row(tri_row(10'd0, 10'd1, 10'd2, 1'b0), 16'sd0, 16'sd0, 16'sd16384,
                      1'b0));
    add_row(typed_row(tri_row(10'd0, 10'd2, 10'd1, 1'b1), 16'sd0, 16'sd0, -16'sd16384,
                      1'b0));
    add_row(typed_row(tri_row(10'd0, 10'd2, 10'd3, 1'b0), 16'sd16384, 16'sd0, 16'sd0,
                      1'b0));
    add_row(typed_row(tri_row(10'd0, 10'd3, 10'd1, 1'b1), 16'sd0, 16'sd16384, 16'sd0,
                      1'b0));
    // collinear through the origin: degenerate
    add_row(typed_row(tri_row(10'd0, 10'd1023, 10'd512, 1'b1), 16'sd0, 16'sd0, 16'sd0,
                      1'b1));
    add_row(tri_row(10'd1023, 10'd512, 10'd4, 1'b0));
    add_row(tri_row(10'd4, 10'd5, 10'd1023, 1'b1));
    add_row(tri_row(10'd512, 10'd4, 10'd5, 1'b0));
    add_row(tri_row(10'd0, 10'd6, 10'd1, 1'b0));
    add_row(tri_row(10'd6, 10'd1, 10'd3, 1'b1));
    foreach (stim_q[i])
      if (!stim_q[i].word.mode && !slot_written[stim_q[i].word.vertex_slot]) begin
        slot_written[stim_q[i].word.vertex_slot] = 1'b1;
        written_slots.insert(written_slots.size(), stim_q[i].word.vertex_slot);
      end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 38) begin
        s = 10'($urandom);
        if (!slot_written[s]) begin
          slot_written[s] = 1'b1;
          written_slots.insert(written_slots.size(), s);
        end
        add_row(vertex_row(s, rand_coord(), rand_coord(), rand_coord()));
      end else begin
        c0 = written_slots[$urandom_range(0, written_slots.size() - 1)];
        c1 = written_slots[$urandom_range(0, written_slots.size() - 1)];
        c2 = written_slots[$urandom_range(0, written_slots.size() - 1)];
        if ($urandom_range(0, 9) == 0) c2 = c1;
        add_row(tri_row(c0, c1, c2, 1'($urandom)));
      end
    end
    foreach (slot_written[i]) slot_written[i] = 1'b0;
  end

  // Sender: bursts of words with random gaps.
  initial begin
    int burst, gap;
    req.valid = 1'b0;
    req.mode = 1'b0;
    req.vertex_slot = '0;
    req.pos_x = '0;
    req.pos_y = '0;
    req.pos_z = '0;
    req.first_corner = '0;
    req.second_corner = '0;
    req.third_corner = '0;
    req.last_triangle = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst = $urandom_range(1, 20);
    foreach (stim_q[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
        if (gap > 0) begin
          req.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      req.valid <= 1'b1;
      req.mode <= stim_q[i].word.mode;
      req.vertex_slot <= stim_q[i].word.vertex_slot;
      req.pos_x <= stim_q[i].word.pos_x;
      req.pos_y <= stim_q[i].word.pos_y;
      req.pos_z <= stim_q[i].word.pos_z;
      req.first_corner <= stim_q[i].word.first_corner;
      req.second_corner <= stim_q[i].word.second_corner;
      req.third_corner <= stim_q[i].word.third_corner;
      req.last_triangle <= stim_q[i].word.last_triangle;
      sent_q.insert(sent_q.size(), stim_q[i]);
      @(posedge clk);
      while (!req.ready) @(posedge clk);
    end
    req.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: phased stall pattern plus one long hold-off to back up the input.
  initial begin
    int hold;
    rsp.ready = 1'b0;
    hold = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (cyc == 4000) hold = 900;
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else begin
        case ((cyc / 500) % 3)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= (cyc % 7) > 2;
          default: rsp.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Accepted input words update the model and queue the expected normal.
  always @(posedge clk) begin
    stim_row_t row;
    if (!rst && req.valid && req.ready) begin
      row = sent_q.pop_front();
      if (!req.mode) begin
        pos_model[req.vertex_slot][0] = int'(req.pos_x);
        pos_model[req.vertex_slot][1] = int'(req.pos_y);
        pos_model[req.vertex_slot][2] = int'(req.pos_z);
      end else if (row.typed) begin
        normal_q.insert(normal_q.size(), row.want);
      end else begin
        normal_q.insert(normal_q.size(),
                        face_normal(req.first_corner, req.second_corner, req.third_corner,
                                    req.last_triangle));
      end
    end
  end

  always @(posedge clk) begin
    normal_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cyc);
      end else begin
        want = normal_q.pop_front();
        if (rsp.normal_x !== want.nx || rsp.normal_y !== want.ny || rsp.normal_z !== want.nz ||
            rsp.degenerate !== want.deg || rsp.end_of_mesh !== want.eom) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cyc %0d: exp %0d %0d %0d deg %b eom %b, got %0d %0d %0d %b %b",
                     cyc, want.nx, want.ny, want.nz, want.deg, want.eom, rsp.normal_x,
                     rsp.normal_y, rsp.normal_z, rsp.degenerate, rsp.end_of_mesh);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    wait (sender_done);
    while (normal_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && normal_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
